FILE: rtl/led_timed_blink_controller_top_defines.svh
// Assertion macros for the LED timed blink controller.
// Used by led_timed_blink_controller_top; expects clk and arst_n in scope.
`ifndef LED_TIMED_BLINK_CONTROLLER_TOP_DEFINES_SVH
`define LED_TIMED_BLINK_CONTROLLER_TOP_DEFINES_SVH

// check a property on every rising clock edge outside reset
`define LTBC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a condition in one cycle implies another in the next
`define LTBC_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/ltbc_pkg.sv
// Shared types and constants of the LED timed blink controller.
// No dependencies.
`default_nettype none

package ltbc_pkg;

	localparam int LED_COUNT_DEF = 16;
	localparam int RESULT_CAP    = 16;
	localparam int CNT_W         = $clog2(RESULT_CAP + 1);

	localparam logic [1:0] REQ_SET   = 2'd0;
	localparam logic [1:0] REQ_TIMED = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam logic [1:0] CFG_ALL_CODE  = 2'd0;
	localparam logic [1:0] CFG_MAX_LEVEL = 2'd1;
	localparam logic [1:0] CFG_OFF_LEVEL = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FLUSH
	} ltbc_state_t;

	typedef enum logic [1:0] {
		KIND_SET,
		KIND_LOAD,
		KIND_TICK
	} ltbc_kind_t;

	typedef struct packed {
		logic       blink;
		logic [7:0] on_count;
		logic [7:0] on_reload;
		logic [7:0] off_count;
		logic [7:0] off_reload;
		logic [7:0] saved_level;
	} ltbc_entry_t;

	typedef struct packed {
		logic       all_leds;
		logic [3:0] led_index;
		logic [7:0] level_res;
	} ltbc_res_t;

endpackage

`default_nettype wire

FILE: rtl/ltbc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module ltbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/led_timed_blink_controller_top.sv
// Top level of the LED timed blink controller: command decode, per-LED timer sweep.
// Depends on ltbc_pkg, ltbc_ram and led_timed_blink_controller_top_defines.svh.
`default_nettype none

// The per-LED timer state lives in one RAM, one entry per LED, visited one entry per
// cycle by a read-modify-write sweep unless stalled. A tick or a timed command for all
// LEDs sweeps every entry, any other command one entry; the sweep stalls on a new word
// while one waits behind a word held at the output. Items are taken only between sweeps,
// while a finished word may still wait at the output. Valid bits per entry, cleared by
// reset, make untouched entries read as zero: there is no clearing pass after reset.
// Results leave one word per command, for a tick one per level change up to RESULT_CAP; tlast on the last.
`include "led_timed_blink_controller_top_defines.svh"

module led_timed_blink_controller_top import ltbc_pkg::*; #(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // position, level, on_time, off_time
	input  wire logic [1:0]  s_axis_tuser,  // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata,  // led_index, level_res, zero fill
	output logic             m_axis_tuser,  // all_leds
	output logic             m_axis_tlast,  // last
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(LED_COUNT - 1);

	ltbc_state_t state_q, state_d;

	logic [7:0] all_code_q, max_level_q, off_level_q;

	logic [1:0] req_type;
	logic [7:0] position, level, on_time, off_time;
	logic       in_acc, pos_all, pos_ok, start_sweep, load_all;
	logic [7:0] pos_m1, set_level;
	logic [IW-1:0] pos_idx, start_idx;

	ltbc_kind_t kind_q;
	logic [7:0] lvl_q, ont_q, offt_q;
	logic       all_q;
	logic [IW-1:0] rd_idx_q, end_q, idx_s1;
	logic       rd_done_q, first_q, first_s1, s1_valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LED_COUNT-1:0] valid_q;

	ltbc_entry_t ram_rdata, ent, nxt;
	logic [7:0]  oc, fc, val;
	logic        wrote, gen, stall, adv, ram_we, out_free, push;
	logic [IW-1:0] ram_raddr;

	ltbc_res_t new_res, pend_q, out_q;
	logic      pend_valid_q, out_valid_q, out_last_q;

	assign req_type = s_axis_tuser;
	assign position = s_axis_tdata[7:0];
	assign level    = s_axis_tdata[15:8];
	assign on_time  = s_axis_tdata[23:16];
	assign off_time = s_axis_tdata[31:24];

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign pos_all   = (position == all_code_q);
	assign pos_m1    = position - 8'd1;
	assign pos_ok    = (pos_m1 < 8'(LED_COUNT));
	assign pos_idx   = pos_all ? '0 : pos_m1[IW-1:0];
	assign set_level = (level >= max_level_q) ? max_level_q : level;
	assign load_all  = (req_type == REQ_TICK) || ((req_type == REQ_TIMED) && pos_all);
	assign start_idx = load_all ? '0 : pos_idx;
	assign start_sweep = in_acc && ((req_type == REQ_TICK) ||
		(((req_type == REQ_SET) || (req_type == REQ_TIMED)) && (pos_all || pos_ok)));

	ltbc_ram #(
		.WIDTH($bits(ltbc_entry_t)),
		.DEPTH(LED_COUNT)
	) u_state_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_s1),
		.wdata(nxt),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign ent = valid_q[idx_s1] ? ram_rdata : '0;

	always_comb begin
		oc    = ent.on_count;
		fc    = ent.off_count;
		val   = '0;
		wrote = 1'b0;
		if (ent.on_count != 8'd0) begin
			oc = ent.on_count - 8'd1;
			if (oc == 8'd0) begin
				val   = off_level_q;
				wrote = 1'b1;
				if (ent.blink) begin
					fc = ent.off_reload;
				end
			end
		end
		if (ent.blink && (oc == 8'd0) && (fc != 8'd0)) begin
			fc = fc - 8'd1;
			if (fc == 8'd0) begin
				val   = ent.saved_level;
				wrote = 1'b1;
				oc    = ent.on_reload;
			end
		end
	end

	always_comb begin
		nxt = ent;
		case (kind_q)
			KIND_TICK: begin
				nxt.on_count  = oc;
				nxt.off_count = fc;
			end
			KIND_LOAD: begin
				if (ont_q == 8'd0) begin
					nxt.blink = 1'b0;
				end else begin
					nxt.on_count    = ont_q;
					nxt.on_reload   = ont_q;
					nxt.saved_level = lvl_q;
					if (offt_q == 8'd0) begin
						nxt.blink = 1'b0;
					end else begin
						nxt.off_count  = offt_q;
						nxt.off_reload = offt_q;
						nxt.blink      = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign gen = s1_valid_q && ((kind_q == KIND_TICK) ?
		(wrote && (cnt_q < CNT_W'(RESULT_CAP))) : first_s1);
	assign new_res.all_leds  = all_q;
	assign new_res.led_index = all_q ? 4'd0 : 4'(idx_s1);
	assign new_res.level_res = (kind_q == KIND_TICK) ? val : lvl_q;

	assign out_free  = !out_valid_q || m_axis_tready;
	assign stall     = gen && pend_valid_q && !out_free;
	assign adv       = (state_q == ST_SWEEP) && !stall;
	assign ram_we    = adv && s1_valid_q && (kind_q != KIND_SET);
	assign ram_raddr = stall ? idx_s1 : rd_idx_q;
	assign push      = (adv && gen && pend_valid_q) ||
		((state_q == ST_FLUSH) && pend_valid_q && out_free);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_sweep) state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (rd_done_q && !s1_valid_q) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!pend_valid_q || out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		cfg_ready     = 1'b1;
		m_axis_tvalid = out_valid_q;
		m_axis_tdata  = {4'd0, out_q.level_res, out_q.led_index};
		m_axis_tuser  = out_q.all_leds;
		m_axis_tlast  = out_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			all_code_q   <= 8'd255;
			max_level_q  <= 8'd248;
			off_level_q  <= 8'd0;
			rd_done_q    <= 1'b1;
			first_q      <= 1'b0;
			s1_valid_q   <= 1'b0;
			cnt_q        <= '0;
			valid_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ALL_CODE:  all_code_q  <= cfg_data;
					CFG_MAX_LEVEL: max_level_q <= cfg_data;
					CFG_OFF_LEVEL: off_level_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if ((state_q == ST_IDLE) && start_sweep) begin
				rd_done_q  <= 1'b0;
				first_q    <= 1'b1;
				s1_valid_q <= 1'b0;
				cnt_q      <= '0;
			end
			if (adv) begin
				s1_valid_q <= !rd_done_q;
				if (!rd_done_q) begin
					first_q <= 1'b0;
					if (rd_idx_q == end_q) rd_done_q <= 1'b1;
				end
				if (gen) begin
					pend_valid_q <= 1'b1;
					if (kind_q == KIND_TICK) cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (ram_we) begin
				valid_q[idx_s1] <= 1'b1;
			end
			if ((state_q == ST_FLUSH) && pend_valid_q && out_free) begin
				pend_valid_q <= 1'b0;
			end
			out_valid_q <= push || (out_valid_q && !m_axis_tready);
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start_sweep) begin
			kind_q   <= (req_type == REQ_TICK) ? KIND_TICK :
				((req_type == REQ_SET) ? KIND_SET : KIND_LOAD);
			lvl_q    <= (req_type == REQ_SET) ? set_level : level;
			ont_q    <= on_time;
			offt_q   <= off_time;
			all_q    <= (req_type != REQ_TICK) && pos_all;
			rd_idx_q <= start_idx;
			end_q    <= load_all ? LAST_IDX : start_idx;
		end
		if (adv && !rd_done_q) begin
			idx_s1   <= rd_idx_q;
			first_s1 <= first_q;
			if (rd_idx_q != end_q) rd_idx_q <= rd_idx_q + IW'(1);
		end
		if (adv && gen) begin
			pend_q <= new_res;
		end
		if (push) begin
			out_q      <= pend_q;
			out_last_q <= (state_q == ST_FLUSH);
		end
	end

	`LTBC_ASSERT(a_idle_no_stage, s_axis_tready |-> !s1_valid_q && !pend_valid_q, "input taken during sweep")
	`LTBC_ASSERT(a_stall_cause, stall |-> out_valid_q && !m_axis_tready, "sweep stalled with free output")
	`LTBC_ASSERT_NEXT(a_busy_after_start, start_sweep, !s_axis_tready && !s1_valid_q, "sweep start missed")
	`LTBC_ASSERT(a_cap, cnt_q <= CNT_W'(RESULT_CAP), "tick result count over cap")

endmodule

`default_nettype wire
